[hw/rtl/smavg_pkg.sv]
package smavg_pkg;

  localparam int CFG_W = 7;
  localparam int WIN_RESET = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_START,
    ST_DIVIDE,
    ST_OUTPUT
  } smavg_state_e;

endpackage

[hw/rtl/smavg_sample_if.sv]
interface smavg_sample_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           restart;

  modport source(output valid, sample, restart, input ready);
  modport sink(input valid, sample, restart, output ready);
endinterface

[hw/rtl/smavg_result_if.sv]
interface smavg_result_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] average;
  logic                           window_full;

  modport source(output valid, average, window_full, input ready);
  modport sink(input valid, average, window_full, output ready);
endinterface

[hw/rtl/smavg_div.sv]
module smavg_div #(
  parameter int DW = 38,
  parameter int VW = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] dividend_i,
  input  logic        [VW-1:0] divisor_i,
  output logic                 done_o,
  output logic signed [DW-1:0] quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic          neg_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dv_q;
  logic [DW-1:0] mag;
  logic [VW:0]   sh;
  logic [VW:0]   diff;
  logic          ge;

  // Restoring division on the magnitude, one quotient bit per cycle.
  assign mag  = dividend_i[DW-1] ? DW'(-dividend_i) : DW'(dividend_i);
  assign sh   = {rem_q, quo_q[DW-1]};
  assign diff = sh - {1'b0, dv_q};
  assign ge   = sh >= {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (start_i) begin
        cnt_q <= CW'(DW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DW-1];
      quo_q <= mag;
      rem_q <= '0;
      dv_q  <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[VW-1:0] : sh[VW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

[hw/rtl/simple_moving_average_core.sv]
// Moving average of signed fixed-point samples over a configurable window.
// A result is computed by a bit-serial divider after its request is taken; one request is
// in work at a time, and a new request is taken only once the last result is loaded.
// A result still waiting on the result side stalls the next one.
// Reset empties the window and sets the window size to 8 (capped at MAX_WINDOW); the sample ring is not cleared.
module simple_moving_average_core
  import smavg_pkg::*;
#(
  parameter int MAX_WINDOW   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  smavg_sample_if.sink     sample_i,
  smavg_result_if.source   result_o
);

  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int OFS_W = CNT_W + 1;
  localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
  localparam int WIN_INIT = (WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_RESET;

  smavg_state_e state_q, state_d;

  logic        [CNT_W-1:0]        win_q;
  logic        [CNT_W-1:0]        fill_q;
  logic        [PTR_W-1:0]        wp_q;
  logic signed [SUM_W-1:0]        sum_q;
  logic signed [SAMPLE_WIDTH-1:0] smp_q;
  logic signed [SAMPLE_WIDTH-1:0] old_q;
  logic signed [SAMPLE_WIDTH-1:0] ring [MAX_WINDOW];
  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] avg_q;
  logic                           full_q;

  logic                    accept;
  logic                    load_out;
  logic                    div_start;
  logic                    div_done;
  logic signed [SUM_W-1:0] quotient;
  logic [CNT_W-1:0]        cfg_win;
  logic [PTR_W-1:0]        base_ptr;
  logic [PTR_W-1:0]        wp_next;
  logic [OFS_W-1:0]        ofs;
  logic [OFS_W-1:0]        ofs_wrap;
  logic [PTR_W-1:0]        old_ptr;

  assign sample_i.ready = (state_q == ST_IDLE);
  assign accept         = sample_i.valid && (state_q == ST_IDLE);
  assign div_start      = (state_q == ST_START);

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_win = CNT_W'(1);
    end else if (int'(cfg_wdata_i) > MAX_WINDOW) begin
      cfg_win = CNT_W'(MAX_WINDOW);
    end else begin
      cfg_win = CNT_W'(cfg_wdata_i);
    end
  end

  // A restart places the new sample at the start of the ring, with the window emptied.
  assign base_ptr = sample_i.restart ? '0 : wp_q;
  assign wp_next  = (base_ptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : base_ptr + PTR_W'(1);
  assign ofs      = OFS_W'(base_ptr) + OFS_W'(MAX_WINDOW) - OFS_W'(win_q);
  assign ofs_wrap = (ofs >= OFS_W'(MAX_WINDOW)) ? ofs - OFS_W'(MAX_WINDOW) : ofs;
  assign old_ptr  = ofs_wrap[PTR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ring[base_ptr] <= sample_i.sample;
      old_q          <= ring[old_ptr];
      smp_q          <= sample_i.sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      win_q   <= CNT_W'(WIN_INIT);
      fill_q  <= '0;
      wp_q    <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        win_q  <= cfg_win;
        fill_q <= '0;
        wp_q   <= '0;
        sum_q  <= '0;
      end else if (accept) begin
        wp_q <= wp_next;
        if (sample_i.restart) begin
          fill_q <= '0;
          sum_q  <= '0;
        end
      end else if (state_q == ST_UPDATE) begin
        if (fill_q < win_q) begin
          sum_q  <= sum_q + SUM_W'(smp_q);
          fill_q <= fill_q + CNT_W'(1);
        end else begin
          sum_q <= sum_q + SUM_W'(smp_q) - SUM_W'(old_q);
        end
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_d = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (!out_valid_q || result_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  smavg_div #(
    .DW(SUM_W),
    .VW(CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_q),
    .divisor_i (fill_q),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      avg_q  <= quotient[SAMPLE_WIDTH-1:0];
      full_q <= (fill_q == win_q);
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.average     = avg_q;
  assign result_o.window_full = full_q;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import smavg_pkg::*;

  localparam int WIDTH = 32;
  localparam int RING_DEPTH = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic signed [WIDTH-1:0] SAMPLE_MAX = 32'sh7fff_ffff;
  localparam logic signed [WIDTH-1:0] SAMPLE_MIN = 32'sh8000_0000;

  typedef struct {
    logic signed [WIDTH-1:0] average;
    logic                    window_full;
  } average_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  smavg_sample_if #(.SAMPLE_WIDTH(WIDTH)) sample_bus ();
  smavg_result_if #(.SAMPLE_WIDTH(WIDTH)) result_bus ();

  simple_moving_average_core #(
    .MAX_WINDOW  (RING_DEPTH),
    .SAMPLE_WIDTH(WIDTH)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .sample_i   (sample_bus),
    .result_o   (result_bus)
  );

  longint          sample_history[RING_DEPTH];
  longint          window_total;
  int              samples_held;
  int              write_slot;
  logic [CFG_W-1:0] window_setting;
  average_t        pending_averages[$];
  average_t        oldest_average;
  int              fail_count;
  int              cycle_count;
  bit              source_gaps_on;
  bit              sink_stalls_on;
  int              stall_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The window is emptied by reset, by a restart request and by every register write.
  function automatic void clear_window();
    window_total = 0;
    samples_held = 0;
    write_slot = 0;
  endfunction

  function automatic void store_expected(input average_t entry);
    pending_averages = {pending_averages, entry};
  endfunction

  function automatic void predict_average(input logic signed [WIDTH-1:0] value,
                                          input logic restart);
    int       span;
    int       oldest;
    longint   quotient;
    average_t result;
    span = (window_setting == 0) ? 1 :
           (window_setting > RING_DEPTH) ? RING_DEPTH : int'(window_setting);
    if (restart) begin
      clear_window();
    end
    if (samples_held < span) begin
      window_total += value;
      samples_held++;
    end else begin
      oldest = (write_slot + RING_DEPTH - span) % RING_DEPTH;
      window_total = window_total + value - sample_history[oldest];
    end
    sample_history[write_slot] = value;
    write_slot = (write_slot + 1) % RING_DEPTH;
    quotient = window_total / longint'(samples_held);
    result.average = quotient[WIDTH-1:0];
    result.window_full = (samples_held == span);
    store_expected(result);
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!source_gaps_on || roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 50);
  endfunction

  function automatic logic signed [WIDTH-1:0] pick_sample();
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: begin
        return SAMPLE_MAX;
      end
      1: begin
        return SAMPLE_MIN;
      end
      2, 3, 4: begin
        return int'($urandom_range(0, 32'h40000)) - 32'sh20000;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  task automatic send_sample(input logic signed [WIDTH-1:0] value, input logic restart);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_bus.valid <= 1'b1;
    sample_bus.sample <= value;
    sample_bus.restart <= restart;
    do @(posedge clk); while (!sample_bus.ready);
    predict_average(value, restart);
  endtask

  task automatic wait_for_results();
    sample_bus.valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] value);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_setting = value;
    clear_window();
  endtask

  task automatic test_field_extremes();
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(32'sh0001_0000, 1'b0);
    send_sample(-32'sd3, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(-32'sh0001_8000, 1'b1);
    send_sample(32'sd7, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
  endtask

  task automatic test_window_limits();
    write_window(7'd0);
    repeat (3) send_sample(pick_sample(), 1'b0);
    write_window(7'd1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    write_window(7'd127);
    repeat (66) send_sample(SAMPLE_MIN, 1'b0);
    write_window(7'd65);
    repeat (4) send_sample(pick_sample(), 1'b0);
    write_window(7'd64);
    repeat (66) send_sample(SAMPLE_MAX, 1'b0);
    repeat (20) send_sample(($urandom_range(0, 1) != 0) ? SAMPLE_MAX : SAMPLE_MIN, 1'b0);
  endtask

  task automatic test_restart();
    write_window(7'd4);
    repeat (3) send_sample(pick_sample(), 1'b0);
    send_sample(32'sh0002_0000, 1'b1);
    repeat (6) send_sample(pick_sample(), 1'b0);
    send_sample(-32'sh0005_0000, 1'b1);
    send_sample(pick_sample(), 1'b1);
    repeat (2) send_sample(pick_sample(), 1'b0);
  endtask

  task automatic test_random_windows();
    logic [CFG_W-1:0] sizes[12];
    sizes = '{7'd1, 7'd2, 7'd3, 7'd7, 7'd8, 7'd16, 7'd33, 7'd63, 7'd64, 7'd0, 7'd100, 7'd5};
    for (int phase = 0; phase < 10; phase++) begin
      source_gaps_on = (phase % 4 != 3);
      sink_stalls_on = (phase % 4 != 3);
      if (phase < 9) begin
        write_window(sizes[$urandom_range(0, 11)]);
      end else begin
        write_window(CFG_W'($urandom_range(0, 127)));
      end
      for (int n = 0; n < 60; n++) begin
        if (n == 40 && phase == 4) begin
          wait_for_results();
        end
        send_sample(pick_sample(), $urandom_range(0, 24) == 0);
      end
    end
    source_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  initial begin
    result_bus.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else begin
        int roll;
        roll = $urandom_range(0, 99);
        if (!sink_stalls_on || roll < 60) begin
          result_bus.ready <= 1'b1;
          stall_left = $urandom_range(0, 5);
        end else if (roll < 92) begin
          result_bus.ready <= 1'b0;
          stall_left = $urandom_range(0, 3);
        end else begin
          result_bus.ready <= 1'b0;
          stall_left = $urandom_range(10, 60);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (pending_averages.size() == 0) begin
        $error("unexpected result: average %0d window_full %0b",
               result_bus.average, result_bus.window_full);
        fail_count++;
      end else begin
        oldest_average = pending_averages.pop_front();
        if (result_bus.average !== oldest_average.average) begin
          $error("average: expected %0d, got %0d", oldest_average.average,
                 result_bus.average);
          fail_count++;
        end
        if (result_bus.window_full !== oldest_average.window_full) begin
          $error("window_full: expected %0b, got %0b", oldest_average.window_full,
                 result_bus.window_full);
          fail_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL simple_moving_average_core");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sample_bus.valid = 1'b0;
    sample_bus.sample = '0;
    sample_bus.restart = 1'b0;
    fail_count = 0;
    source_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
    window_setting = CFG_W'(WIN_RESET);
    clear_window();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_window_limits();
    test_restart();
    test_random_windows();

    wait_for_results();
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS simple_moving_average_core");
    end else begin
      $display("FAIL simple_moving_average_core");
    end
    $finish;
  end

endmodule
